// File: hw/rtl/sbi_pkg.sv
// Shared constants and types for the segment against box intersection test.
`timescale 1ns / 1ps
`default_nettype none

package sbi_pkg;

    // Default coordinate width: signed Q12.12 in 24 bits.
    localparam int COORD_WIDTH_DEFAULT = 24;

    // Width of the configuration register index.
    localparam int CFG_INDEX_WIDTH = 4;

    typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

    // Configuration register indexes.
    localparam cfg_index_t REG_BOX_LEFT   = cfg_index_t'(0);
    localparam cfg_index_t REG_BOX_TOP    = cfg_index_t'(1);
    localparam cfg_index_t REG_BOX_RIGHT  = cfg_index_t'(2);
    localparam cfg_index_t REG_BOX_BOTTOM = cfg_index_t'(3);

    // Per-item decision flags that ride along the pipeline.
    typedef struct packed {
        logic box_ok;    // Box top is not below box bottom.
        logic vert;      // Segment has no x extent.
        logic vert_le;   // Some end point y is at or above the bottom edge.
        logic vert_ge;   // Some end point y is at or below the top edge.
        logic dy_neg;    // Segment y falls from start to end.
    } seg_flags_t;

endpackage

`default_nettype wire

// File: hw/rtl/segment_box_intersect.sv
// Top level: pipelined test of a 2D segment against an axis-aligned box.
//
//  Channel   Signals                                   Transfer when
//  input     start, busy, start_x/y, end_x/y           start && !busy at a rising edge
//  result    done, hit                                 done high, one cycle per result
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid && cfg_ready
//
// One segment is taken every cycle while busy is low; each result appears in
// order after its transfer has passed the five register stages: sort, clip,
// offset, multiply, compare. The y tests are done by comparing cross products,
// so no divider is needed. busy is high only in the cycle that follows reset
// release and during reset; no stalls occur, and the receiver takes every result.
`timescale 1ns / 1ps
`default_nettype none

module segment_box_intersect #(
    parameter int COORD_WIDTH = sbi_pkg::COORD_WIDTH_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Segment input
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic signed [COORD_WIDTH-1:0]       start_x,
    input  wire logic signed [COORD_WIDTH-1:0]       start_y,
    input  wire logic signed [COORD_WIDTH-1:0]       end_x,
    input  wire logic signed [COORD_WIDTH-1:0]       end_y,
    // Result
    output logic                                     done,
    output logic                                     hit,
    // Configuration writes
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [sbi_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic signed [COORD_WIDTH-1:0]       cfg_data
);

    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;       // coordinate difference
    localparam int MW = W + 2;       // bound multiplier
    localparam int PW = 2 * W;       // unsigned product
    localparam int QW = 2 * W + 3;   // signed bound product

    // Box registers.
    logic signed [W-1:0] box_left_reg;
    logic signed [W-1:0] box_top_reg;
    logic signed [W-1:0] box_right_reg;
    logic signed [W-1:0] box_bottom_reg;

    logic busy_reg;

    // Stage 1: differences, x sort, y offsets to the box edges.
    logic                 s1_valid_reg;
    logic signed [DW-1:0] s1_dx_reg,   s1_dx_next;
    logic signed [DW-1:0] s1_dy_reg,   s1_dy_next;
    logic signed [W-1:0]  s1_minx_reg, s1_minx_next;
    logic signed [W-1:0]  s1_maxx_reg, s1_maxx_next;
    logic signed [W-1:0]  s1_x0_reg;
    logic signed [DW-1:0] s1_kb_reg,   s1_kb_next;
    logic signed [DW-1:0] s1_kt_reg,   s1_kt_next;
    logic                 s1_vle_reg,  s1_vle_next;
    logic                 s1_vge_reg,  s1_vge_next;
    logic                 s1_boxok_reg, s1_boxok_next;

    // Stage 2: clipped x span, magnitudes, bound multipliers.
    logic                    s2_valid_reg;
    logic signed [W-1:0]     s2_lox_reg, s2_lox_next;
    logic signed [W-1:0]     s2_hix_reg, s2_hix_next;
    logic signed [W-1:0]     s2_x0_reg;
    logic        [W-1:0]     s2_c_reg,   s2_c_next;
    logic        [W-1:0]     s2_ady_reg, s2_ady_next;
    logic signed [MW-1:0]    s2_mb_reg,  s2_mb_next;
    logic signed [MW-1:0]    s2_mt_reg,  s2_mt_next;
    logic                    s2_dxneg_reg;
    sbi_pkg::seg_flags_t     s2_flags_reg, s2_flags_next;

    // Stage 3: empty span check and offsets along x.
    logic                    s3_valid_reg;
    logic                    s3_empty_reg, s3_empty_next;
    logic        [W-1:0]     s3_ta_reg,  s3_ta_next;
    logic        [W-1:0]     s3_tb_reg,  s3_tb_next;
    logic        [W-1:0]     s3_c_reg;
    logic        [W-1:0]     s3_ady_reg;
    logic signed [MW-1:0]    s3_mb_reg;
    logic signed [MW-1:0]    s3_mt_reg;
    sbi_pkg::seg_flags_t     s3_flags_reg;

    // Stage 4: products.
    logic                    s4_valid_reg;
    logic                    s4_empty_reg;
    logic        [PW-1:0]    s4_pa_reg, s4_pa_next;
    logic        [PW-1:0]    s4_pb_reg, s4_pb_next;
    logic signed [QW-1:0]    s4_qb_reg, s4_qb_next;
    logic signed [QW-1:0]    s4_qt_reg, s4_qt_next;
    sbi_pkg::seg_flags_t     s4_flags_reg;

    // Output registers.
    logic done_reg;
    logic hit_reg, hit_next;

    logic in_xfer;

    assign in_xfer   = start && !busy_reg;
    assign busy      = busy_reg;
    assign cfg_ready = !busy_reg;
    assign done      = done_reg;
    assign hit       = hit_reg;

    // Configuration register writes; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_left_reg   <= '0;
            box_top_reg    <= '0;
            box_right_reg  <= '0;
            box_bottom_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sbi_pkg::REG_BOX_LEFT:   box_left_reg   <= cfg_data;
                sbi_pkg::REG_BOX_TOP:    box_top_reg    <= cfg_data;
                sbi_pkg::REG_BOX_RIGHT:  box_right_reg  <= cfg_data;
                sbi_pkg::REG_BOX_BOTTOM: box_bottom_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Stage 1 logic.
    always_comb
    begin
        s1_dx_next    = $signed({end_x[W-1], end_x}) - $signed({start_x[W-1], start_x});
        s1_dy_next    = $signed({end_y[W-1], end_y}) - $signed({start_y[W-1], start_y});
        s1_minx_next  = (start_x < end_x) ? start_x : end_x;
        s1_maxx_next  = (start_x < end_x) ? end_x : start_x;
        s1_kb_next    = $signed({box_bottom_reg[W-1], box_bottom_reg})
                      - $signed({start_y[W-1], start_y});
        s1_kt_next    = $signed({box_top_reg[W-1], box_top_reg})
                      - $signed({start_y[W-1], start_y});
        s1_vle_next   = (start_y <= box_bottom_reg) || (end_y <= box_bottom_reg);
        s1_vge_next   = (start_y >= box_top_reg) || (end_y >= box_top_reg);
        s1_boxok_next = (box_top_reg <= box_bottom_reg);
    end

    // Stage 2 logic: clip x to the box and set up the y bound multipliers.
    // For dy >= 0 the end y is at or above the bottom edge exactly when
    // |dy|*|t| < (bottom - y0 + 1)*|dx|; the other cases follow the same
    // pattern with the sign folded into the multiplier.
    always_comb
    begin
        logic signed [MW-1:0] kb_ext;
        logic signed [MW-1:0] kt_ext;
        logic signed [DW-1:0] dx_mag;
        logic signed [DW-1:0] dy_mag;

        kb_ext = $signed({s1_kb_reg[DW-1], s1_kb_reg});
        kt_ext = $signed({s1_kt_reg[DW-1], s1_kt_reg});
        dx_mag = s1_dx_reg[DW-1] ? -s1_dx_reg : s1_dx_reg;
        dy_mag = s1_dy_reg[DW-1] ? -s1_dy_reg : s1_dy_reg;

        s2_lox_next = (s1_minx_reg < box_left_reg)  ? box_left_reg  : s1_minx_reg;
        s2_hix_next = (s1_maxx_reg > box_right_reg) ? box_right_reg : s1_maxx_reg;
        s2_c_next   = dx_mag[W-1:0];
        s2_ady_next = dy_mag[W-1:0];
        s2_mb_next  = s1_dy_reg[DW-1] ? -kb_ext : kb_ext + MW'(1);
        s2_mt_next  = s1_dy_reg[DW-1] ? MW'(1) - kt_ext : kt_ext;

        s2_flags_next.box_ok  = s1_boxok_reg;
        s2_flags_next.vert    = (s1_dx_reg == '0);
        s2_flags_next.vert_le = s1_vle_reg;
        s2_flags_next.vert_ge = s1_vge_reg;
        s2_flags_next.dy_neg  = s1_dy_reg[DW-1];
    end

    // Stage 3 logic: distance from the start point along x to each clipped end.
    always_comb
    begin
        logic signed [DW-1:0] lo_ext;
        logic signed [DW-1:0] hi_ext;
        logic signed [DW-1:0] x0_ext;
        logic signed [DW-1:0] ta_full;
        logic signed [DW-1:0] tb_full;

        lo_ext = $signed({s2_lox_reg[W-1], s2_lox_reg});
        hi_ext = $signed({s2_hix_reg[W-1], s2_hix_reg});
        x0_ext = $signed({s2_x0_reg[W-1], s2_x0_reg});

        ta_full = s2_dxneg_reg ? (x0_ext - lo_ext) : (lo_ext - x0_ext);
        tb_full = s2_dxneg_reg ? (x0_ext - hi_ext) : (hi_ext - x0_ext);

        s3_empty_next = (s2_lox_reg > s2_hix_reg);
        s3_ta_next    = ta_full[W-1:0];
        s3_tb_next    = tb_full[W-1:0];
    end

    // Stage 4 logic: the four products.
    always_comb
    begin
        s4_pa_next = PW'(s3_ady_reg) * PW'(s3_ta_reg);
        s4_pb_next = PW'(s3_ady_reg) * PW'(s3_tb_reg);
        s4_qb_next = QW'(s3_mb_reg) * QW'($signed({1'b0, s3_c_reg}));
        s4_qt_next = QW'(s3_mt_reg) * QW'($signed({1'b0, s3_c_reg}));
    end

    // Stage 5 logic: compare the products and combine the edge tests.
    always_comb
    begin
        logic signed [QW-1:0] pa_ext;
        logic signed [QW-1:0] pb_ext;
        logic                 le_a;
        logic                 le_b;
        logic                 ge_a;
        logic                 ge_b;
        logic                 y_hit;

        pa_ext = $signed({3'b000, s4_pa_reg});
        pb_ext = $signed({3'b000, s4_pb_reg});

        le_a = s4_flags_reg.dy_neg ? (pa_ext >= s4_qb_reg) : (pa_ext < s4_qb_reg);
        le_b = s4_flags_reg.dy_neg ? (pb_ext >= s4_qb_reg) : (pb_ext < s4_qb_reg);
        ge_a = s4_flags_reg.dy_neg ? (pa_ext < s4_qt_reg)  : (pa_ext >= s4_qt_reg);
        ge_b = s4_flags_reg.dy_neg ? (pb_ext < s4_qt_reg)  : (pb_ext >= s4_qt_reg);

        y_hit = s4_flags_reg.vert ? (s4_flags_reg.vert_le && s4_flags_reg.vert_ge)
                                  : ((le_a || le_b) && (ge_a || ge_b));

        hit_next = !s4_empty_reg && s4_flags_reg.box_ok && y_hit;
    end

    // Valid bits and the busy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b1;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            busy_reg     <= 1'b0;
            s1_valid_reg <= in_xfer;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            done_reg     <= s4_valid_reg;
        end
    end

    // Pipeline payload registers.
    always_ff @(posedge clk)
    begin
        s1_dx_reg     <= s1_dx_next;
        s1_dy_reg     <= s1_dy_next;
        s1_minx_reg   <= s1_minx_next;
        s1_maxx_reg   <= s1_maxx_next;
        s1_x0_reg     <= start_x;
        s1_kb_reg     <= s1_kb_next;
        s1_kt_reg     <= s1_kt_next;
        s1_vle_reg    <= s1_vle_next;
        s1_vge_reg    <= s1_vge_next;
        s1_boxok_reg  <= s1_boxok_next;

        s2_lox_reg    <= s2_lox_next;
        s2_hix_reg    <= s2_hix_next;
        s2_x0_reg     <= s1_x0_reg;
        s2_c_reg      <= s2_c_next;
        s2_ady_reg    <= s2_ady_next;
        s2_mb_reg     <= s2_mb_next;
        s2_mt_reg     <= s2_mt_next;
        s2_dxneg_reg  <= s1_dx_reg[DW-1];
        s2_flags_reg  <= s2_flags_next;

        s3_empty_reg  <= s3_empty_next;
        s3_ta_reg     <= s3_ta_next;
        s3_tb_reg     <= s3_tb_next;
        s3_c_reg      <= s2_c_reg;
        s3_ady_reg    <= s2_ady_reg;
        s3_mb_reg     <= s2_mb_reg;
        s3_mt_reg     <= s2_mt_reg;
        s3_flags_reg  <= s2_flags_reg;

        s4_empty_reg  <= s3_empty_reg;
        s4_pa_reg     <= s4_pa_next;
        s4_pb_reg     <= s4_pb_next;
        s4_qb_reg     <= s4_qb_next;
        s4_qt_reg     <= s4_qt_next;
        s4_flags_reg  <= s3_flags_reg;

        hit_reg       <= hit_next;
    end

    // Every result comes from an earlier input transfer that passed all the stages.
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(start && !busy_reg, 5))
        else $error("result strobe without a matching input transfer");

    // Every input transfer yields a result once it has passed all the stages.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy_reg) |-> ##5 done_reg)
        else $error("input transfer lost in the pipeline");

    // A segment whose x span misses the box never hits.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s4_valid_reg && s4_empty_reg) |=> !hit_reg)
        else $error("hit reported for an empty x span");

    // An inverted box never hits.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s4_valid_reg && !s4_flags_reg.box_ok) |=> !hit_reg)
        else $error("hit reported for an inverted box");

    // Once busy has dropped after reset it stays low.
    assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |=> !busy_reg)
        else $error("busy raised again after reset");

endmodule

`default_nettype wire
